// ----- design/ucal_pkg.sv -----
// ----------------------------------------------------------------------------
// ucal_pkg
// Shared types and constants of the seconds-to-calendar converter.
// ----------------------------------------------------------------------------
package ucal_pkg;

  // Time of day as it travels down the pipeline.
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  // Whole days since the epoch together with the time of day.
  typedef struct packed {
    logic [15:0] days;
    tod_t        tod;
  } days_tod_t;

  // Complete result beat.
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    tod_t        tod;
  } date_time_t;

  // Division by 60: floor(x * M / 2^37) is exact for every 32-bit x.
  localparam logic [31:0] DIV60_MAGIC = 32'h8888_8889;
  localparam int          DIV60_SHIFT = 37;

  // Division by 3 for values below 2^18: floor(x * M / 2^20).
  localparam logic [18:0] DIV3_MAGIC = 19'd349526;
  localparam int          DIV3_SHIFT = 20;

  // Julian-day style date chain.
  localparam logic [18:0] DAY_BIAS_A    = 19'd102032;
  localparam logic [18:0] GREG_CYCLE    = 19'd146097;
  localparam logic [18:0] GREG_CYCLE_X2 = GREG_CYCLE << 1;
  localparam logic [21:0] JD_OFFSET     = 22'd2442113;
  localparam logic [25:0] YEAR_BIAS     = 26'd2442;
  localparam logic [21:0] DAYS_PER_YEAR = 22'd365;

  // Division by 7305 for values below 2^26: floor(x * M / 2^39).
  localparam logic [26:0] YEAR_MAGIC = 27'd75257470;
  localparam int          YEAR_SHIFT = 39;

  // floor(d * 1000 / 30601) for d below 2^9: floor(d * M / 2^34), with the
  // factor of 1000 folded into the reciprocal.
  localparam logic [29:0] MONTH_MAGIC = 30'd561416000;
  localparam int          MONTH_SHIFT = 34;

  localparam logic [3:0]  MONTH_WRAP    = 4'd13;
  localparam logic [12:0] YEAR_SUB_LOW  = 13'd4716;
  localparam logic [12:0] YEAR_SUB_HIGH = 13'd4715;

  // floor(e * 601 / 1000) for the month index e.
  function automatic logic [3:0] month_frac(input logic [3:0] e);
    logic [3:0] r;
    case (e)
      4'd0, 4'd1:   r = 4'd0;
      4'd2, 4'd3:   r = 4'd1;
      4'd4:         r = 4'd2;
      4'd5, 4'd6:   r = 4'd3;
      4'd7, 4'd8:   r = 4'd4;
      4'd9:         r = 4'd5;
      4'd10, 4'd11: r = 4'd6;
      4'd12, 4'd13: r = 4'd7;
      4'd14:        r = 4'd8;
      4'd15:        r = 4'd9;
      default:      r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/ucal_in_if.sv -----
// ----------------------------------------------------------------------------
// ucal_in_if
// Timestamp channel: one count of seconds since the epoch per beat.
// ----------------------------------------------------------------------------
interface ucal_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] unix_seconds;

  modport source (output valid, output unix_seconds, input ready);
  modport sink   (input valid, input unix_seconds, output ready);
endinterface

// ----- design/ucal_out_if.sv -----
// ----------------------------------------------------------------------------
// ucal_out_if
// Calendar channel: date and time of day per beat.
// ----------------------------------------------------------------------------
interface ucal_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  modport source (output valid, output year, output month, output day,
                  output hour, output minute, output second, input ready);
  modport sink   (input valid, input year, input month, input day,
                  input hour, input minute, input second, output ready);
endinterface

// ----- design/unix_seconds_to_calendar_core.sv -----
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar_core
// Converts seconds since 1970-01-01 00:00 UTC into a Gregorian date and time.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one 32-bit unsigned seconds count per beat; out_ch returns
//   year, month, day, hour, minute and second for it, one beat per input
//   beat and in the same order. Both channels use valid/ready; a beat moves
//   on a rising edge with both high.
// Pipeline and throughput:
//   Ten register stages: four split off seconds, minutes and hours with
//   reciprocal multiplications, six run the day-number chain to the date.
//   One beat can enter in every cycle while out_ch takes its results.
// Stalls:
//   Every stage has its own valid bit and loads when it is empty or its beat
//   moves on, so bubbles close up while out_ch is held. in_ch.ready only
//   falls once all ten stages hold a beat and out_ch is not taking one.
// Reset:
//   rst_n (synchronous, active low) clears the valid bits and so empties the
//   pipeline; the data registers are not reset.
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar_core import ucal_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ucal_in_if.sink    in_ch,
  ucal_out_if.source out_ch
);

  logic       mid_valid;
  logic       mid_ready;
  days_tod_t  mid_data;
  date_time_t res_data;

  ucal_tod_split u_tod_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_secs   (in_ch.unix_seconds),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (mid_data)
  );

  ucal_date_calc u_date_calc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_data   (mid_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (res_data)
  );

  assign out_ch.year   = res_data.year;
  assign out_ch.month  = res_data.month;
  assign out_ch.day    = res_data.day;
  assign out_ch.hour   = res_data.tod.hour;
  assign out_ch.minute = res_data.tod.minute;
  assign out_ch.second = res_data.tod.second;

endmodule

// ----- design/ucal_tod_split.sv -----
// ----------------------------------------------------------------------------
// ucal_tod_split
// Four-stage pipeline that splits seconds into days, hours, minutes, seconds.
// ----------------------------------------------------------------------------
module ucal_tod_split import ucal_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_secs,
  output logic        out_valid,
  input  logic        out_ready,
  output days_tod_t   out_data
);

  localparam int Stages = 4;

  logic [Stages-1:0] vld_r;
  logic [Stages-1:0] adv;

  // A stage takes new contents when it is empty or its own beat moves on.
  always_comb begin
    adv[Stages-1] = !vld_r[Stages-1] || out_ready;
    for (int k = Stages - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < Stages; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[Stages-1];

  // Stage 1: minutes since the epoch.
  logic [63:0] s1_prod;
  logic [26:0] s1_q1_nxt, s1_q1_r;
  logic [5:0]  s1_t6_r;

  assign s1_prod   = 64'(in_secs) * 64'(DIV60_MAGIC);
  assign s1_q1_nxt = s1_prod[DIV60_SHIFT+26:DIV60_SHIFT];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_q1_r <= s1_q1_nxt;
      s1_t6_r <= in_secs[5:0];
    end
  end

  // Stage 2: second of minute, hours since the epoch.
  // The remainder is below 64, so the low six bits of the operands suffice.
  logic [63:0] s2_prod;
  logic [20:0] s2_q2_nxt, s2_q2_r;
  logic [5:0]  s2_sec_nxt, s2_sec_r;
  logic [5:0]  s2_q1l_r;

  assign s2_prod    = 64'(s1_q1_r) * 64'(DIV60_MAGIC);
  assign s2_q2_nxt  = s2_prod[DIV60_SHIFT+20:DIV60_SHIFT];
  assign s2_sec_nxt = s1_t6_r - 6'(s1_q1_r[5:0] * 6'd60);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_q2_r  <= s2_q2_nxt;
      s2_sec_r <= s2_sec_nxt;
      s2_q1l_r <= s1_q1_r[5:0];
    end
  end

  // Stage 3: minute of hour, days since the epoch (hours / 8 / 3).
  logic [36:0] s3_prod;
  logic [15:0] s3_days_nxt, s3_days_r;
  logic [5:0]  s3_min_nxt, s3_min_r;
  logic [5:0]  s3_sec_r;
  logic [4:0]  s3_q2l_r;

  assign s3_prod     = 37'(s2_q2_r[20:3]) * 37'(DIV3_MAGIC);
  assign s3_days_nxt = s3_prod[DIV3_SHIFT+15:DIV3_SHIFT];
  assign s3_min_nxt  = s2_q1l_r - 6'(s2_q2_r[5:0] * 6'd60);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_days_r <= s3_days_nxt;
      s3_min_r  <= s3_min_nxt;
      s3_sec_r  <= s2_sec_r;
      s3_q2l_r  <= s2_q2_r[4:0];
    end
  end

  // Stage 4: hour of day.
  days_tod_t s4_nxt, s4_r;

  always_comb begin
    s4_nxt.days       = s3_days_r;
    s4_nxt.tod.hour   = s3_q2l_r - 5'(s3_days_r[4:0] * 5'd24);
    s4_nxt.tod.minute = s3_min_r;
    s4_nxt.tod.second = s3_sec_r;
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_r <= s4_nxt;
    end
  end

  assign out_data = s4_r;

  a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.tod.hour < 5'd24 && out_data.tod.minute < 6'd60 &&
                   out_data.tod.second < 6'd60))
    else $error("time of day out of range");

endmodule

// ----- design/ucal_date_calc.sv -----
// ----------------------------------------------------------------------------
// ucal_date_calc
// Six-stage pipeline that turns days since the epoch into year, month, day.
// ----------------------------------------------------------------------------
module ucal_date_calc import ucal_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  days_tod_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output date_time_t out_data
);

  localparam int Stages = 6;

  logic [Stages-1:0] vld_r;
  logic [Stages-1:0] adv;

  always_comb begin
    adv[Stages-1] = !vld_r[Stages-1] || out_ready;
    for (int k = Stages - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < Stages; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[Stages-1];

  // Stage 1: century correction and Julian-style day number.
  // The quotient by the 400-year cycle is only ever 0, 1 or 2 here.
  logic [18:0] s1_v;
  logic [4:0]  s1_a;
  logic [21:0] s1_b_nxt, s1_b_r;
  tod_t        s1_tod_r;

  always_comb begin
    s1_v     = 19'({in_data.days, 2'b00}) + DAY_BIAS_A;
    s1_a     = 5'd15 + 5'(s1_v >= GREG_CYCLE) + 5'(s1_v >= GREG_CYCLE_X2);
    s1_b_nxt = 22'(in_data.days) + JD_OFFSET + 22'(s1_a) - 22'(s1_a >> 2);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_b_r   <= s1_b_nxt;
      s1_tod_r <= in_data.tod;
    end
  end

  // Stage 2: numerator of the year estimate, 20 * b - bias.
  logic [25:0] s2_x_nxt, s2_x_r;
  logic [21:0] s2_b_r;
  tod_t        s2_tod_r;

  assign s2_x_nxt = {s1_b_r, 4'b0000} + 26'({s1_b_r, 2'b00}) - YEAR_BIAS;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_x_r   <= s2_x_nxt;
      s2_b_r   <= s1_b_r;
      s2_tod_r <= s1_tod_r;
    end
  end

  // Stage 3: year estimate by reciprocal multiplication.
  logic [52:0] s3_prod;
  logic [12:0] s3_c_nxt, s3_c_r;
  logic [21:0] s3_b_r;
  tod_t        s3_tod_r;

  assign s3_prod  = 53'(s2_x_r) * 53'(YEAR_MAGIC);
  assign s3_c_nxt = s3_prod[YEAR_SHIFT+12:YEAR_SHIFT];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_c_r   <= s3_c_nxt;
      s3_b_r   <= s2_b_r;
      s3_tod_r <= s2_tod_r;
    end
  end

  // Stage 4: day within the March-based year.
  logic [21:0] s4_d_full;
  logic [8:0]  s4_d_r;
  logic [12:0] s4_c_r;
  tod_t        s4_tod_r;

  assign s4_d_full = s3_b_r - 22'(s3_c_r) * DAYS_PER_YEAR - 22'(s3_c_r >> 2);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_d_r   <= s4_d_full[8:0];
      s4_c_r   <= s3_c_r;
      s4_tod_r <= s3_tod_r;
    end
  end

  // Stage 5: month index by reciprocal multiplication.
  logic [38:0] s5_prod;
  logic [3:0]  s5_e_nxt, s5_e_r;
  logic [8:0]  s5_d_r;
  logic [12:0] s5_c_r;
  tod_t        s5_tod_r;

  assign s5_prod  = 39'(s4_d_r) * 39'(MONTH_MAGIC);
  assign s5_e_nxt = s5_prod[MONTH_SHIFT+3:MONTH_SHIFT];

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_e_r   <= s5_e_nxt;
      s5_d_r   <= s4_d_r;
      s5_c_r   <= s4_c_r;
      s5_tod_r <= s4_tod_r;
    end
  end

  // Stage 6: day of month, and January and February move to the next year.
  logic [8:0]  s6_f_full;
  logic [12:0] s6_y_full;
  date_time_t  s6_nxt, s6_r;

  always_comb begin
    s6_f_full = s5_d_r - 9'(s5_e_r) * 9'd30 - 9'(month_frac(s5_e_r));
    if (s5_e_r <= MONTH_WRAP) begin
      s6_y_full    = s5_c_r - YEAR_SUB_LOW;
      s6_nxt.month = s5_e_r - 4'd1;
    end else begin
      s6_y_full    = s5_c_r - YEAR_SUB_HIGH;
      s6_nxt.month = s5_e_r - MONTH_WRAP;
    end
    s6_nxt.year = s6_y_full[11:0];
    s6_nxt.day  = s6_f_full[4:0];
    s6_nxt.tod  = s5_tod_r;
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s6_r <= s6_nxt;
    end
  end

  assign out_data = s6_r;

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.month >= 4'd1 && out_data.month <= 4'd12))
    else $error("month out of range");

  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.day >= 5'd1))
    else $error("day of month is zero");

  a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.year >= 12'd1970 && out_data.year <= 12'd2106))
    else $error("year out of range");

endmodule
